// ===== sv/arle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arle_pkg
// Shared constants, types and helpers of the channel list range encoder.
// ----------------------------------------------------------------------------
package arle_pkg;

  // Capacity and tree depth.
  localparam int MAX_CHANNELS = 29;
  localparam int STACK_LEVELS = 6;

  // Field widths.
  localparam int CH_W    = 10;
  localparam int RANGE_W = 11;
  localparam int IDX_W   = 6;

  // Derived widths.
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int AW    = $clog2(MAX_CHANNELS);
  localparam int LVL_W = $clog2(STACK_LEVELS + 1);
  localparam int I_W   = ((CNT_W > STACK_LEVELS) ? CNT_W : STACK_LEVELS) + 2;

  // Range register limits.
  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(512);
  localparam logic [RANGE_W-1:0] RANGE_MIN   = RANGE_W'(2);
  localparam logic [RANGE_W-1:0] RANGE_MAX   = RANGE_W'(1024);

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT0,
    S_RED_RD,
    S_RED_LD,
    S_RED_DIV,
    S_RED_WR,
    S_K_START,
    S_LVL,
    S_PIV_A,
    S_PIV_AL,
    S_PIV_BR,
    S_PIV_BC,
    S_PIV_CHK,
    S_PIV_DONE,
    S_FLT_RD,
    S_FLT_CMP,
    S_NEXT,
    S_RES_RD,
    S_RES_LD,
    S_EMIT
  } state_e;

  // Working set buffers.
  typedef enum logic [1:0] {
    BUF_BASE,
    BUF_A,
    BUF_B
  } buf_e;

  // Modulo reduction of a difference that lies within one range of [0, r).
  function automatic logic [CH_W-1:0] pmod_small(input logic signed [CH_W+1:0] d,
                                                 input logic [CH_W-1:0] r);
    logic signed [CH_W+1:0] rs;
    logic signed [CH_W+1:0] t;
    rs = signed'({2'b00, r});
    if (d < 0) begin
      t = d + rs;
    end else if (d >= rs) begin
      t = d - rs;
    end else begin
      t = d;
    end
    return t[CH_W-1:0];
  endfunction

endpackage

// ===== sv/arle_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arle_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module arle_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/arfcn_range_list_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arfcn_range_list_encoder_core
// Range coding of a sorted channel list into its W list.
// ----------------------------------------------------------------------------
// Usage: channel items enter on the in channel (valid/ready), one per cycle
// while the block is idle. The item with last high closes the list and starts
// the encoding; in_ready_o stays low until the last W value of the list has
// been loaded into the output register. Items beyond the capacity are
// discarded and flagged on every result.
// Results leave on the out channel (valid/ready) in index order, W(0) first,
// from one output register; a stalled receiver simply holds the sequencer.
// Sequence: W(0) is loaded into the output register in S_EMIT0 once that
// register is free. Then every channel after the first is reduced modulo the
// range with an 11-step shift-subtract unit, and each further W(k) walks the
// tree from the root: per level a pivot search and a filter pass over the
// working set of that level.
// The encoding range register may be written only while the block is idle.
// Reset empties the list, clears the overflow flag and sets the range to 512.
// ----------------------------------------------------------------------------
module arfcn_range_list_encoder_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       encoding_range_we_i,
  input  logic [arle_pkg::RANGE_W-1:0] encoding_range_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [arle_pkg::CH_W-1:0]  channel_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [arle_pkg::IDX_W-1:0] w_index_o,
  output logic [arle_pkg::CH_W-1:0]  w_value_o,
  output logic                       overflow_o,
  output logic                       end_of_list_o
);
  import arle_pkg::*;

  // Control state.
  state_e              state_q, state_d;
  logic [RANGE_W-1:0]  range_q;
  logic [CNT_W-1:0]    count_q;
  logic                ovf_q;
  logic                out_valid_q;

  // Datapath registers.
  logic [CH_W-1:0]     ch0_q;
  logic [CNT_W-1:0]    k_q, n_q, a_q, b_q, m_q, cnt_q, pidx_q;
  logic [I_W-1:0]      i_q;
  logic [LVL_W-1:0]    lvl_q;
  logic [CH_W-1:0]     r_q, xa_q, x0_q, piv_q, org_q, res_q;
  buf_e                src_q;
  logic                red_neg_q;
  logic [RANGE_W-1:0]  red_u_q;
  logic [CH_W-1:0]     red_rem_q;
  logic [3:0]          red_bit_q;
  logic                left_q;

  // Output registers.
  logic [IDX_W-1:0]    out_idx_q;
  logic [CH_W-1:0]     out_val_q;
  logic                out_ovf_q, out_eol_q;

  // RAM ports.
  logic                ch_we, base_we, wa_we, wb_we;
  logic [AW-1:0]       ch_raddr, w_raddr, w_waddr;
  logic [CH_W-1:0]     ch_rd, base_rd, wa_rd, wb_rd, rd_data, w_wdata;

  // Combinational helpers.
  logic                in_acc, out_free, lvl_stop, piv_hit, pivot_ok, flt_keep;
  logic                left_nx, last_k;
  logic [CH_W-1:0]     r0, half_r, flt_v, org_nx, red_fin, rem_nx, r_nx;
  logic [RANGE_W-1:0]  rem_sh;
  logic signed [CH_W+1:0] red_x;
  logic [I_W-1:0]      k_ext, dk;
  buf_e                dst;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign last_k   = (k_q == count_q - CNT_W'(1));

  // Range clamped to its limits, minus one.
  always_comb begin
    if (range_q < RANGE_MIN) begin
      r0 = CH_W'(1);
    end else if (range_q > RANGE_MAX) begin
      r0 = CH_W'(RANGE_MAX - RANGE_W'(1));
    end else begin
      r0 = CH_W'(range_q - RANGE_W'(1));
    end
  end

  // Working set read mux.
  always_comb begin
    case (src_q)
      BUF_BASE: rd_data = base_rd;
      BUF_A:    rd_data = wa_rd;
      BUF_B:    rd_data = wb_rd;
      default:  rd_data = base_rd;
    endcase
  end
  assign dst = (src_q == BUF_A) ? BUF_B : BUF_A;

  // Compare logic for pivot search and filtering.
  assign half_r   = (r_q - CH_W'(1)) >> 1;
  assign piv_hit  = pmod_small(signed'({2'b00, rd_data}) - signed'({2'b00, xa_q}), r_q)
                    <= half_r;
  assign pivot_ok = ((cnt_q - CNT_W'(1)) == ((n_q - CNT_W'(1)) >> 1));
  assign flt_v    = pmod_small(signed'({2'b00, rd_data}) - signed'({2'b00, org_q}), r_q);
  assign flt_keep = flt_v < (r_q >> 1);

  // Walk control.
  assign k_ext    = I_W'(k_q);
  assign lvl_stop = (lvl_q >= LVL_W'(STACK_LEVELS)) || (i_q > k_ext);
  assign dk       = (k_ext - i_q) >> lvl_q;
  assign left_nx  = dk[0];
  assign org_nx   = left_nx ?
      pmod_small(signed'({2'b00, piv_q}) + signed'({2'b00, half_r}) + 12'sd1, r_q) :
      pmod_small(signed'({2'b00, piv_q}) + 12'sd1, r_q);
  always_comb begin
    r_nx = left_q ? (r_q >> 1) : ((r_q - CH_W'(1)) >> 1);
    if (r_nx == '0) begin
      r_nx = CH_W'(1);
    end
  end

  // Reduction unit: one shift-subtract step per cycle.
  assign red_x   = signed'({2'b00, ch_rd}) - signed'({2'b00, ch0_q}) - 12'sd1;
  assign rem_sh  = {red_rem_q, red_u_q[RANGE_W-1]};
  assign rem_nx  = (rem_sh >= {1'b0, r_q}) ? CH_W'(rem_sh - {1'b0, r_q}) : CH_W'(rem_sh);
  assign red_fin = (red_neg_q && red_rem_q != '0) ? (r_q - red_rem_q) : red_rem_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_acc && last_i) state_d = S_EMIT0;
      S_EMIT0: begin
        if (out_free) state_d = (count_q == CNT_W'(1)) ? S_IDLE : S_RED_RD;
      end
      S_RED_RD:   state_d = S_RED_LD;
      S_RED_LD:   state_d = S_RED_DIV;
      S_RED_DIV:  if (red_bit_q == '0) state_d = S_RED_WR;
      S_RED_WR: begin
        state_d = (a_q + CNT_W'(2) == count_q) ? S_K_START : S_RED_RD;
      end
      S_K_START:  state_d = S_LVL;
      S_LVL: begin
        if (lvl_stop || n_q == '0) begin
          state_d = S_EMIT;
        end else if (n_q == CNT_W'(1)) begin
          state_d = (i_q == k_ext) ? S_RES_RD : S_EMIT;
        end else begin
          state_d = S_PIV_A;
        end
      end
      S_PIV_A:    state_d = S_PIV_AL;
      S_PIV_AL:   state_d = S_PIV_BR;
      S_PIV_BR:   state_d = S_PIV_BC;
      S_PIV_BC:   state_d = (b_q + CNT_W'(1) == n_q) ? S_PIV_CHK : S_PIV_BR;
      S_PIV_CHK: begin
        if (pivot_ok || a_q + CNT_W'(1) == n_q) state_d = S_PIV_DONE;
        else state_d = S_PIV_A;
      end
      S_PIV_DONE: state_d = (i_q == k_ext) ? S_RES_RD : S_FLT_RD;
      S_FLT_RD:   state_d = S_FLT_CMP;
      S_FLT_CMP:  state_d = (a_q + CNT_W'(1) == n_q) ? S_NEXT : S_FLT_RD;
      S_NEXT:     state_d = S_LVL;
      S_RES_RD:   state_d = S_RES_LD;
      S_RES_LD:   state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) state_d = last_k ? S_IDLE : S_K_START;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Memory control.
  always_comb begin
    ch_raddr = AW'(a_q + CNT_W'(1));
    w_raddr  = a_q[AW-1:0];
    base_we  = 1'b0;
    wa_we    = 1'b0;
    wb_we    = 1'b0;
    w_waddr  = m_q[AW-1:0];
    w_wdata  = flt_v;
    case (state_q)
      S_RED_WR: begin
        base_we = 1'b1;
        w_waddr = a_q[AW-1:0];
        w_wdata = red_fin;
      end
      S_PIV_BR:  w_raddr = b_q[AW-1:0];
      S_FLT_CMP: begin
        wa_we = flt_keep && (dst == BUF_A);
        wb_we = flt_keep && (dst == BUF_B);
      end
      S_RES_RD: begin
        ch_raddr = AW'(pidx_q + CNT_W'(1));
        w_raddr  = pidx_q[AW-1:0];
      end
      default: ;
    endcase
  end

  assign ch_we = in_acc && (count_q < CNT_W'(MAX_CHANNELS));

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers: range, list count, overflow flag and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q     <= RANGE_RESET;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (encoding_range_we_i) begin
        range_q <= encoding_range_i;
      end
      if (in_acc) begin
        if (count_q < CNT_W'(MAX_CHANNELS)) count_q <= count_q + CNT_W'(1);
        else ovf_q <= 1'b1;
      end
      if ((state_q == S_EMIT0 || state_q == S_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
        if ((state_q == S_EMIT0 && count_q == CNT_W'(1)) || (state_q == S_EMIT && last_k)) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath of the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc && count_q == '0) ch0_q <= channel_i;
      end
      S_EMIT0: begin
        if (out_free) begin
          out_idx_q <= '0;
          out_val_q <= ch0_q;
          out_ovf_q <= ovf_q;
          out_eol_q <= (count_q == CNT_W'(1));
        end
        a_q <= '0;
        k_q <= CNT_W'(1);
        r_q <= r0;
      end
      S_RED_LD: begin
        red_neg_q <= red_x < 0;
        red_u_q   <= (red_x < 0) ? RANGE_W'(-red_x) : RANGE_W'(red_x);
        red_rem_q <= '0;
        red_bit_q <= 4'(RANGE_W - 1);
      end
      S_RED_DIV: begin
        red_rem_q <= rem_nx;
        red_u_q   <= red_u_q << 1;
        red_bit_q <= red_bit_q - 4'd1;
      end
      S_RED_WR:  a_q <= a_q + CNT_W'(1);
      S_K_START: begin
        i_q   <= I_W'(1);
        lvl_q <= '0;
        r_q   <= r0;
        n_q   <= count_q - CNT_W'(1);
        src_q <= BUF_BASE;
      end
      S_LVL: begin
        a_q    <= '0;
        res_q  <= '0;
        pidx_q <= '0;
      end
      S_PIV_AL: begin
        xa_q  <= rd_data;
        if (a_q == '0) x0_q <= rd_data;
        b_q   <= '0;
        cnt_q <= '0;
      end
      S_PIV_BC: begin
        if (piv_hit) cnt_q <= cnt_q + CNT_W'(1);
        b_q <= b_q + CNT_W'(1);
      end
      S_PIV_CHK: begin
        if (pivot_ok) begin
          piv_q  <= xa_q;
          pidx_q <= a_q;
        end else if (a_q + CNT_W'(1) == n_q) begin
          piv_q  <= x0_q;
          pidx_q <= '0;
        end else begin
          a_q <= a_q + CNT_W'(1);
        end
      end
      S_PIV_DONE: begin
        left_q <= left_nx;
        org_q  <= org_nx;
        a_q    <= '0;
        m_q    <= '0;
      end
      S_FLT_CMP: begin
        if (flt_keep) m_q <= m_q + CNT_W'(1);
        a_q <= a_q + CNT_W'(1);
      end
      S_NEXT: begin
        n_q   <= m_q;
        i_q   <= i_q + (left_q ? (I_W'(1) << lvl_q) : (I_W'(2) << lvl_q));
        r_q   <= r_nx;
        lvl_q <= lvl_q + LVL_W'(1);
        src_q <= dst;
      end
      S_RES_LD: begin
        // The top level works on raw offsets, deeper levels on reduced ones.
        res_q <= (lvl_q == '0) ? (ch_rd - ch0_q) : (rd_data + CH_W'(1));
      end
      S_EMIT: begin
        if (out_free) begin
          out_idx_q <= IDX_W'(k_q);
          out_val_q <= res_q;
          out_ovf_q <= ovf_q;
          out_eol_q <= last_k;
          k_q       <= k_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Channel store and working set buffers.
  arle_ram #(.WIDTH(CH_W), .DEPTH(MAX_CHANNELS)) u_ch_ram (
    .clk_i  (clk_i),
    .we_i   (ch_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(channel_i),
    .raddr_i(ch_raddr),
    .rdata_o(ch_rd)
  );

  arle_ram #(.WIDTH(CH_W), .DEPTH(MAX_CHANNELS)) u_base_ram (
    .clk_i  (clk_i),
    .we_i   (base_we),
    .waddr_i(w_waddr),
    .wdata_i(w_wdata),
    .raddr_i(w_raddr),
    .rdata_o(base_rd)
  );

  arle_ram #(.WIDTH(CH_W), .DEPTH(MAX_CHANNELS)) u_wa_ram (
    .clk_i  (clk_i),
    .we_i   (wa_we),
    .waddr_i(w_waddr),
    .wdata_i(w_wdata),
    .raddr_i(w_raddr),
    .rdata_o(wa_rd)
  );

  arle_ram #(.WIDTH(CH_W), .DEPTH(MAX_CHANNELS)) u_wb_ram (
    .clk_i  (clk_i),
    .we_i   (wb_we),
    .waddr_i(w_waddr),
    .wdata_i(w_wdata),
    .raddr_i(w_raddr),
    .rdata_o(wb_rd)
  );

  // Ports.
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign w_index_o     = out_idx_q;
  assign w_value_o     = out_val_q;
  assign overflow_o    = out_ovf_q;
  assign end_of_list_o = out_eol_q;

endmodule
